// ----- hw/rtl/rptf_pkg.sv -----
// Shared constants and types for the ROM page translation block.
`timescale 1ns / 1ps

package rptf_pkg;

  localparam int FRAMES     = 64;
  localparam int PAGE_BYTES = 65536;
  localparam int PAGES      = 2048;

  localparam int ADDR_IN_W = 32;
  localparam int ADDR_W    = 27;
  localparam int ROM_W     = 28;
  localparam int FRAME_W   = $clog2(FRAMES);
  localparam int PAGE_W    = $clog2(PAGES);
  localparam int OFFSET_W  = $clog2(PAGE_BYTES);

  localparam int RES_W      = 1 + 1 + PAGE_W + FRAME_W + OFFSET_W + 1 + PAGE_W;
  localparam int OUT_DATA_W = ((RES_W + 7) / 8) * 8;

  typedef struct packed {
    logic               valid;
    logic [FRAME_W-1:0] frame;
  } pm_entry_t;

  typedef struct packed {
    logic              rd_en;
    logic [PAGE_W-1:0] rd_addr;
    logic              wr_en;
    logic [PAGE_W-1:0] wr_addr;
    pm_entry_t         wr_data;
  } pm_req_t;

  typedef struct packed {
    logic [PAGE_W-1:0]   evicted_page;
    logic                evicted;
    logic [OFFSET_W-1:0] offset;
    logic [FRAME_W-1:0]  frame;
    logic [PAGE_W-1:0]   page;
    logic                hit;
    logic                in_range;
  } result_t;

endpackage

// ----- hw/rtl/rptf_page_map.sv -----
// Page map memory: one entry per page, cleared by a sweep after reset.
`timescale 1ns / 1ps

module rptf_page_map
  import rptf_pkg::*;
(
  input  logic      clk,
  input  logic      rst,
  input  pm_req_t   req,
  output logic      busy,
  output pm_entry_t rd_data
);

  pm_entry_t         mem [PAGES];
  logic              clearing;
  logic [PAGE_W-1:0] clear_addr;

  always_ff @(posedge clk) begin
    if (rst) begin
      clearing   <= 1'b1;
      clear_addr <= '0;
    end else if (clearing) begin
      if (clear_addr == PAGE_W'(PAGES - 1)) begin
        clearing <= 1'b0;
      end
      clear_addr <= clear_addr + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (clearing) begin
      mem[clear_addr] <= '0;
    end else if (req.wr_en) begin
      mem[req.wr_addr] <= req.wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (req.rd_en) begin
      rd_data <= mem[req.rd_addr];
    end
  end

  assign busy = clearing;

endmodule

// ----- hw/rtl/rptf_frame_table.sv -----
// Frame owner table with the FIFO victim pointer and a wrap flag.
`timescale 1ns / 1ps

module rptf_frame_table
  import rptf_pkg::*;
(
  input  logic               clk,
  input  logic               rst,
  input  logic               rd_en,
  input  logic               upd_en,
  input  logic [PAGE_W-1:0]  upd_page,
  output logic [FRAME_W-1:0] victim,
  output logic               victim_owned,
  output logic [PAGE_W-1:0]  owner_page
);

  logic [PAGE_W-1:0]  owner_mem [FRAMES];
  logic [FRAME_W-1:0] victim_pointer;
  logic               wrapped;

  // Frames fill in order and are never freed, so the frame under the
  // pointer holds a page exactly when the pointer has wrapped once.
  always_ff @(posedge clk) begin
    if (rst) begin
      victim_pointer <= '0;
      wrapped        <= 1'b0;
    end else if (upd_en) begin
      if (victim_pointer == FRAME_W'(FRAMES - 1)) begin
        victim_pointer <= '0;
        wrapped        <= 1'b1;
      end else begin
        victim_pointer <= victim_pointer + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (upd_en) begin
      owner_mem[victim_pointer] <= upd_page;
    end
    if (rd_en) begin
      owner_page <= owner_mem[victim_pointer];
    end
  end

  assign victim       = victim_pointer;
  assign victim_owned = wrapped;

  // The pointer moves only when a frame is taken.
  assert property (@(posedge clk) disable iff (rst) !upd_en |=> $stable(victim_pointer))
    else $error("victim pointer moved without an update");

endmodule

// ----- hw/rtl/rom_page_translate_fifo_unit.sv -----
// Top level of the ROM page translator with FIFO frame replacement.
`timescale 1ns / 1ps

// Usage:
// A ROM byte address arrives as a transaction on the s_axis channel. Only its
// low 27 bits count. One result transaction leaves on m_axis per address: the
// range flag, hit flag, page, frame, offset and any page that was evicted.
// The rom_bytes register is to be written through cfg_we / cfg_wdata only
// while idle; the block does not enforce it. Each address goes through
// accept plus the synchronous page map and frame table reads, then deciding
// and writing the new mapping, then unmapping an evicted page and loading
// the output register; the single page map write port keeps the last two
// apart. A new address is taken only once the last result is loaded. After
// reset the page map is cleared by a sweep of all 2048 entries, one entry per
// cycle; s_axis_tready stays low until it ends, while cfg writes are taken.
// When the receiver stalls, the finished result waits in the output register
// and the next item waits in its final step, so nothing is lost.

module rom_page_translate_fifo_unit
  import rptf_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  cfg_we,
  input  logic [ROM_W-1:0]      cfg_wdata,     // rom_bytes
  input  logic                  s_axis_tvalid,
  output logic                  s_axis_tready,
  input  logic [ADDR_IN_W-1:0]  s_axis_tdata,  // address
  output logic                  m_axis_tvalid,
  input  logic                  m_axis_tready,
  // in_range, hit, page, frame, offset, evicted, evicted_page, zero pad
  output logic [OUT_DATA_W-1:0] m_axis_tdata
);

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_LOOK = 2'd1;
  localparam logic [1:0] S_DONE = 2'd2;

  logic [1:0]          state;
  logic [ROM_W-1:0]    rom_bytes;
  logic [ADDR_W-1:0]   addr_q;
  logic                in_range_q;
  result_t             res;
  logic                out_valid;
  result_t             out_res;

  logic [ADDR_W-1:0]   in_addr;
  logic [ADDR_W-1:0]   in_page_wide;
  logic [ADDR_W-1:0]   q_page_wide;
  logic [PAGE_W-1:0]   q_page;
  logic                in_accept;
  logic                out_load;

  pm_req_t             pm_req;
  logic                pm_busy;
  pm_entry_t           pm_rd;

  logic [FRAME_W-1:0]  victim;
  logic                victim_owned;
  logic [PAGE_W-1:0]   owner_page;
  logic                look_miss;

  // Address split: the masked address gives the page and the offset.
  assign in_addr      = s_axis_tdata[ADDR_W-1:0];
  assign in_page_wide = in_addr >> OFFSET_W;
  assign q_page_wide  = addr_q >> OFFSET_W;
  assign q_page       = q_page_wide[PAGE_W-1:0];

  assign s_axis_tready = (state == S_IDLE) && !pm_busy;
  assign in_accept     = s_axis_tvalid && s_axis_tready;
  assign out_load      = (state == S_DONE) && (!out_valid || m_axis_tready);
  assign look_miss     = (state == S_LOOK) && in_range_q && !pm_rd.valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      rom_bytes <= '0;
    end else if (cfg_we) begin
      rom_bytes <= cfg_wdata;
    end
  end

  // Both tables are read at the accept edge; their data is ready in S_LOOK.
  // The new mapping is written in S_LOOK and the evicted page is unmapped in
  // S_DONE, so every write lands before the next item's read.
  always_comb begin
    pm_req         = '0;
    pm_req.rd_en   = in_accept;
    pm_req.rd_addr = in_page_wide[PAGE_W-1:0];
    if (look_miss) begin
      pm_req.wr_en         = 1'b1;
      pm_req.wr_addr       = q_page;
      pm_req.wr_data.valid = 1'b1;
      pm_req.wr_data.frame = victim;
    end else if (state == S_DONE && res.evicted) begin
      pm_req.wr_en   = 1'b1;
      pm_req.wr_addr = res.evicted_page;
    end
  end

  rptf_page_map u_page_map (
    .clk     (clk),
    .rst     (rst),
    .req     (pm_req),
    .busy    (pm_busy),
    .rd_data (pm_rd)
  );

  rptf_frame_table u_frame_table (
    .clk          (clk),
    .rst          (rst),
    .rd_en        (in_accept),
    .upd_en       (look_miss),
    .upd_page     (q_page),
    .victim       (victim),
    .victim_owned (victim_owned),
    .owner_page   (owner_page)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      case (state)
        S_IDLE: begin
          if (in_accept) begin
            state <= S_LOOK;
          end
        end
        S_LOOK: begin
          state <= S_DONE;
        end
        S_DONE: begin
          if (out_load) begin
            state <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  // Item payload captured at accept. Out-of-range items write no table.
  always_ff @(posedge clk) begin
    if (in_accept) begin
      addr_q     <= in_addr;
      in_range_q <= ({1'b0, in_addr} <= rom_bytes);
    end
  end

  always_ff @(posedge clk) begin
    if (state == S_LOOK) begin
      res.in_range     <= in_range_q;
      res.hit          <= in_range_q && pm_rd.valid;
      res.page         <= q_page;
      res.offset       <= addr_q[OFFSET_W-1:0];
      res.frame        <= !in_range_q ? '0 : (pm_rd.valid ? pm_rd.frame : victim);
      res.evicted      <= look_miss && victim_owned;
      res.evicted_page <= (look_miss && victim_owned) ? owner_page : '0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_load) begin
      out_valid <= 1'b1;
    end else if (m_axis_tready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      out_res <= res;
    end
  end

  assign m_axis_tvalid = out_valid;
  assign m_axis_tdata  = OUT_DATA_W'(out_res);

  // A new item is never taken while the page map is still being cleared.
  assert property (@(posedge clk) disable iff (rst) in_accept |-> !pm_busy)
    else $error("address accepted during the page map clear");

  // An out-of-range result reports no hit, no frame and no eviction.
  assert property (@(posedge clk) disable iff (rst)
      out_valid && !out_res.in_range |->
        !out_res.hit && !out_res.evicted && out_res.frame == '0)
    else $error("out-of-range result carries table data");

  // A hit never evicts a page.
  assert property (@(posedge clk) disable iff (rst)
      out_valid && out_res.hit |-> !out_res.evicted)
    else $error("hit result reports an eviction");

  // The evicted page never equals the page just mapped.
  assert property (@(posedge clk) disable iff (rst)
      state == S_DONE && res.evicted |-> res.evicted_page != res.page)
    else $error("eviction unmaps the page just mapped");

endmodule
